// File: hw/rtl/lbm_pkg.sv
// ----------------------------------------------------------------------------
// lbm_pkg
// Shared constants, types and direction maps of the D2Q9 collision block.
// ----------------------------------------------------------------------------
package lbm_pkg;

  localparam int DEF_VALUE_WIDTH    = 32;
  localparam int DEF_FRAC_BITS      = 28;
  localparam int DEF_NUM_COMPONENTS = 2;

  localparam int OMEGA_W     = 30;
  localparam int DIR_W       = 4;
  localparam int NODE_W      = 20;
  localparam int ROW_W       = 11;
  localparam int COUNT_W     = 21;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 30;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [OMEGA_W-1:0] OMEGA_RESET      = 30'd268435456;
  localparam logic [ROW_W-1:0]   ROW_WIDTH_RESET  = 11'd64;
  localparam logic [COUNT_W-1:0] NODE_COUNT_RESET = 21'd4096;

  localparam logic [DIR_W-1:0] DIR_REST = 4'd0;
  localparam logic [DIR_W-1:0] DIR_MAX  = 4'd8;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_OMEGA0     = 3'd0,
    CFG_OMEGA1     = 3'd1,
    CFG_ROW_WIDTH  = 3'd2,
    CFG_NODE_COUNT = 3'd3,
    CFG_SLIP_NORTH = 3'd4
  } cfg_reg_e;

  // What the back end has to do with one classified item.
  typedef struct packed {
    logic             relax;
    logic             wr_en;
    logic [DIR_W-1:0] dir;
  } ctrl_t;

  typedef struct packed {
    logic valid;
  } front_stat_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

  function automatic logic [DIR_W-1:0] bounce_dir(input logic [DIR_W-1:0] d);
    logic [DIR_W-1:0] r;
    case (d)
      4'd1:    r = 4'd3;
      4'd2:    r = 4'd4;
      4'd3:    r = 4'd1;
      4'd4:    r = 4'd2;
      4'd5:    r = 4'd7;
      4'd6:    r = 4'd8;
      4'd7:    r = 4'd5;
      4'd8:    r = 4'd6;
      default: r = 4'd0;
    endcase
    return r;
  endfunction

  function automatic logic [DIR_W-1:0] mirror_dir(input logic [DIR_W-1:0] d);
    logic [DIR_W-1:0] r;
    case (d)
      4'd1:    r = 4'd1;
      4'd2:    r = 4'd4;
      4'd3:    r = 4'd3;
      4'd4:    r = 4'd2;
      4'd5:    r = 4'd8;
      4'd6:    r = 4'd7;
      4'd7:    r = 4'd6;
      4'd8:    r = 4'd5;
      default: r = 4'd0;
    endcase
    return r;
  endfunction

endpackage

// File: hw/rtl/lbm_front.sv
// ----------------------------------------------------------------------------
// lbm_front
// Accepts items, classifies them (relax, bounce back, slip or no write) and
// forms the operand magnitude for the multiplier.
// ----------------------------------------------------------------------------
module lbm_front #(
  parameter int VALUE_WIDTH    = lbm_pkg::DEF_VALUE_WIDTH,
  parameter int NUM_COMPONENTS = lbm_pkg::DEF_NUM_COMPONENTS,
  parameter int IN_TW          = 88,
  parameter int MAG_W          = 33,
  parameter int DATA_W         = 1 + lbm_pkg::OMEGA_W + 33 + 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [IN_TW-1:0]                in_data_i,
  input  logic [1:0]                      in_user_i,
  input  logic [lbm_pkg::OMEGA_W-1:0]     omega0_i,
  input  logic [lbm_pkg::OMEGA_W-1:0]     omega1_i,
  input  logic [lbm_pkg::ROW_W-1:0]       row_width_i,
  input  logic [lbm_pkg::COUNT_W-1:0]     node_count_i,
  input  logic                            slip_north_i,
  output logic                            push_valid_o,
  input  logic                            push_ready_i,
  output lbm_pkg::ctrl_t                  push_ctrl_o,
  output logic [DATA_W-1:0]               push_data_o,
  output lbm_pkg::front_stat_t            stat_o
);

  localparam int VW = VALUE_WIDTH;
  localparam int DIR_LSB = lbm_pkg::NODE_W;
  localparam int PRE_LSB = lbm_pkg::NODE_W + lbm_pkg::DIR_W;
  localparam int EQ_LSB  = PRE_LSB + VW;

  logic                          valid_q;
  lbm_pkg::ctrl_t                ctrl_q, ctrl_d;
  logic [DATA_W-1:0]             data_q, data_d;

  logic [lbm_pkg::NODE_W-1:0]    node;
  logic [lbm_pkg::DIR_W-1:0]     dir;
  logic [VW-1:0]                 pre, eq;
  logic                          comp, solid;
  logic [lbm_pkg::COUNT_W-1:0]   row_ext, thr;
  logic                          top;
  logic [VW:0]                   diff, absd;
  logic                          neg;
  logic [lbm_pkg::OMEGA_W-1:0]   omega;
  logic                          accept;

  assign node  = in_data_i[lbm_pkg::NODE_W-1:0];
  assign dir   = in_data_i[DIR_LSB +: lbm_pkg::DIR_W];
  assign pre   = in_data_i[PRE_LSB +: VW];
  assign eq    = in_data_i[EQ_LSB +: VW];
  assign comp  = in_user_i[0];
  assign solid = in_user_i[1];

  // Top row when the index reaches node_count - row_width, floored at zero.
  assign row_ext = lbm_pkg::COUNT_W'(row_width_i);
  assign thr     = (node_count_i > row_ext) ? node_count_i - row_ext : '0;
  assign top     = lbm_pkg::COUNT_W'(node) >= thr;

  assign diff = {pre[VW-1], pre} - {eq[VW-1], eq};
  assign neg  = diff[VW];
  assign absd = neg ? -diff : diff;

  assign omega = (NUM_COMPONENTS > 1 && comp) ? omega1_i : omega0_i;

  always_comb begin
    ctrl_d.relax = 1'b0;
    ctrl_d.wr_en = 1'b0;
    ctrl_d.dir   = dir;
    if (dir <= lbm_pkg::DIR_MAX) begin
      if (!solid) begin
        ctrl_d.relax = 1'b1;
        ctrl_d.wr_en = 1'b1;
      end else if (dir != lbm_pkg::DIR_REST) begin
        ctrl_d.dir   = (slip_north_i && top) ? lbm_pkg::mirror_dir(dir)
                                             : lbm_pkg::bounce_dir(dir);
        ctrl_d.wr_en = 1'b1;
      end
    end
    data_d = {neg, omega, absd[MAG_W-1:0], pre};
  end

  assign in_ready_o = !valid_q || push_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (accept) begin
      valid_q <= 1'b1;
    end else if (push_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ctrl_q <= ctrl_d;
      data_q <= data_d;
    end
  end

  assign push_valid_o = valid_q;
  assign push_ctrl_o  = ctrl_q;
  assign push_data_o  = data_q;
  assign stat_o.valid = valid_q;

endmodule

// File: hw/rtl/lbm_queue.sv
// ----------------------------------------------------------------------------
// lbm_queue
// Short first-in first-out queue between the classifier and the arithmetic.
// ----------------------------------------------------------------------------
module lbm_queue #(
  parameter int DATA_W = 96
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_valid_i,
  output logic                  push_ready_o,
  input  lbm_pkg::ctrl_t        push_ctrl_i,
  input  logic [DATA_W-1:0]     push_data_i,
  output logic                  pop_valid_o,
  input  logic                  pop_ready_i,
  output lbm_pkg::ctrl_t        pop_ctrl_o,
  output logic [DATA_W-1:0]     pop_data_o,
  output lbm_pkg::queue_stat_t  stat_o
);

  localparam int DEPTH = lbm_pkg::QUEUE_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  lbm_pkg::ctrl_t     ctrl_mem [DEPTH];
  logic [DATA_W-1:0]  data_mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]   count_q;
  logic               full, empty, push, pop;

  assign full  = count_q == CNT_W'(DEPTH);
  assign empty = count_q == '0;
  assign push  = push_valid_i && !full;
  assign pop   = pop_ready_i && !empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      ctrl_mem[wr_ptr_q] <= push_ctrl_i;
      data_mem[wr_ptr_q] <= push_data_i;
    end
  end

  assign push_ready_o = !full;
  assign pop_valid_o  = !empty;
  assign pop_ctrl_o   = ctrl_mem[rd_ptr_q];
  assign pop_data_o   = data_mem[rd_ptr_q];
  assign stat_o.full  = full;
  assign stat_o.empty = empty;

endmodule

// File: hw/rtl/lbm_back.sv
// ----------------------------------------------------------------------------
// lbm_back
// Relaxation pipeline: split multiply, rounding, subtract and clamp, and the
// output register that holds a result until it is taken.
// ----------------------------------------------------------------------------
module lbm_back #(
  parameter int VALUE_WIDTH = lbm_pkg::DEF_VALUE_WIDTH,
  parameter int FRAC_BITS   = lbm_pkg::DEF_FRAC_BITS,
  parameter int MAG_W       = 33,
  parameter int DATA_W      = 1 + lbm_pkg::OMEGA_W + 33 + 32,
  parameter int OUT_TW      = 40
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  pop_valid_i,
  output logic                  pop_ready_o,
  input  lbm_pkg::ctrl_t        pop_ctrl_i,
  input  logic [DATA_W-1:0]     pop_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [OUT_TW-1:0]     out_data_o,
  output logic [1:0]            out_user_o
);

  localparam int VW     = VALUE_WIDTH;
  localparam int OW     = lbm_pkg::OMEGA_W;
  localparam int LO_W   = MAG_W / 2;
  localparam int HI_W   = MAG_W - LO_W;
  localparam int PROD_W = MAG_W + OW;
  localparam int SUM_W  = PROD_W + 1;
  localparam int RES_W  = SUM_W + 2;
  localparam logic [SUM_W-1:0] HALF = {{(SUM_W-1){1'b0}}, 1'b1} << (FRAC_BITS - 1);
  localparam logic signed [RES_W-1:0] MAX_V = {{(RES_W-VW+1){1'b0}}, {(VW-1){1'b1}}};
  localparam logic signed [RES_W-1:0] MIN_V = {{(RES_W-VW+1){1'b1}}, {(VW-1){1'b0}}};

  logic                 en;

  // Operand fields of a queued item.
  logic [VW-1:0]        in_pre;
  logic [MAG_W-1:0]     in_mag;
  logic [OW-1:0]        in_omega;
  logic                 in_neg;

  // Multiply stage.
  logic                 a_valid_q;
  lbm_pkg::ctrl_t       a_ctrl_q;
  logic                 a_neg_q;
  logic [VW-1:0]        a_pre_q;
  logic [LO_W+OW-1:0]   a_pp_lo_q;
  logic [HI_W+OW-1:0]   a_pp_hi_q;

  // Rounding stage.
  logic                 b_valid_q;
  lbm_pkg::ctrl_t       b_ctrl_q;
  logic                 b_neg_q;
  logic [VW-1:0]        b_pre_q;
  logic [SUM_W-1:0]     b_quot_q;
  logic [SUM_W-1:0]     sum;

  // Output register.
  logic                 o_valid_q;
  logic [OUT_TW-1:0]    o_data_q;
  logic [1:0]           o_user_q;

  logic signed [RES_W-1:0] pre_x, quot_x, res;
  logic                    over, under, sat;
  logic [VW-1:0]           value;

  assign in_pre   = pop_data_i[VW-1:0];
  assign in_mag   = pop_data_i[VW +: MAG_W];
  assign in_omega = pop_data_i[VW+MAG_W +: OW];
  assign in_neg   = pop_data_i[VW+MAG_W+OW];

  // The whole pipeline moves whenever the output slot is free or being taken.
  assign en          = !o_valid_q || out_ready_i;
  assign pop_ready_o = en;

  assign sum = SUM_W'({a_pp_hi_q, {LO_W{1'b0}}}) + SUM_W'(a_pp_lo_q) + HALF;

  assign pre_x  = $signed({{(RES_W-VW){b_pre_q[VW-1]}}, b_pre_q});
  assign quot_x = $signed({2'b00, b_quot_q});
  assign res    = b_neg_q ? pre_x + quot_x : pre_x - quot_x;
  assign over   = res > MAX_V;
  assign under  = res < MIN_V;

  always_comb begin
    sat   = 1'b0;
    value = b_pre_q;
    if (b_ctrl_q.relax) begin
      sat = over || under;
      if (over) begin
        value = MAX_V[VW-1:0];
      end else if (under) begin
        value = MIN_V[VW-1:0];
      end else begin
        value = res[VW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else if (en) begin
      a_valid_q <= pop_valid_i;
      b_valid_q <= a_valid_q;
      o_valid_q <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_ctrl_q  <= pop_ctrl_i;
      a_neg_q   <= in_neg;
      a_pre_q   <= in_pre;
      a_pp_lo_q <= in_mag[LO_W-1:0] * in_omega;
      a_pp_hi_q <= in_mag[MAG_W-1:LO_W] * in_omega;

      b_ctrl_q  <= a_ctrl_q;
      b_neg_q   <= a_neg_q;
      b_pre_q   <= a_pre_q;
      b_quot_q  <= sum >> FRAC_BITS;

      o_data_q  <= OUT_TW'({value, b_ctrl_q.dir});
      o_user_q  <= {sat, b_ctrl_q.wr_en};
    end
  end

  assign out_valid_o = o_valid_q;
  assign out_data_o  = o_data_q;
  assign out_user_o  = o_user_q;

endmodule

// File: hw/rtl/lbm_d2q9_collide_bounce_back.sv
// ----------------------------------------------------------------------------
// lbm_d2q9_collide_bounce_back
// D2Q9 BGK collision with bounce-back and north slip, one element per item.
// ----------------------------------------------------------------------------
// An accepted item passes the front register, the queue, the two-stage
// multiply and round pipeline and the output register. Throughput: one item
// per cycle when the output is not stalled. The queue holds four items.
// Reset clears all valid bits and queue pointers and loads the register
// defaults; no clearing pass follows, an item may be taken in the next cycle.
module lbm_d2q9_collide_bounce_back #(
  parameter int VALUE_WIDTH    = lbm_pkg::DEF_VALUE_WIDTH,
  parameter int FRAC_BITS      = lbm_pkg::DEF_FRAC_BITS,
  parameter int NUM_COMPONENTS = lbm_pkg::DEF_NUM_COMPONENTS,
  localparam int IN_TW  = ((lbm_pkg::NODE_W + lbm_pkg::DIR_W + 2 * VALUE_WIDTH + 7) / 8) * 8,
  localparam int OUT_TW = ((lbm_pkg::DIR_W + VALUE_WIDTH + 7) / 8) * 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // node_index, direction, pre_value, eq_value, zero fill
  input  logic [IN_TW-1:0]                s_axis_tdata,
  // component, solid
  input  logic [1:0]                      s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // out_direction, out_value, zero fill
  output logic [OUT_TW-1:0]               m_axis_tdata,
  // write_enable, saturated
  output logic [1:0]                      m_axis_tuser,
  input  logic                            cfg_we_i,
  input  logic [lbm_pkg::CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [lbm_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  localparam int MAG_W  = (VALUE_WIDTH + 1 > 64) ? 64 : VALUE_WIDTH + 1;
  localparam int DATA_W = 1 + lbm_pkg::OMEGA_W + MAG_W + VALUE_WIDTH;

  logic [lbm_pkg::OMEGA_W-1:0] omega0_q, omega1_q;
  logic [lbm_pkg::ROW_W-1:0]   row_width_q;
  logic [lbm_pkg::COUNT_W-1:0] node_count_q;
  logic                        slip_north_q;

  logic                  push_valid, push_ready, pop_valid, pop_ready;
  lbm_pkg::ctrl_t        push_ctrl, pop_ctrl;
  logic [DATA_W-1:0]     push_data, pop_data;
  lbm_pkg::front_stat_t  front_stat;
  lbm_pkg::queue_stat_t  queue_stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      omega0_q     <= lbm_pkg::OMEGA_RESET;
      omega1_q     <= lbm_pkg::OMEGA_RESET;
      row_width_q  <= lbm_pkg::ROW_WIDTH_RESET;
      node_count_q <= lbm_pkg::NODE_COUNT_RESET;
      slip_north_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (lbm_pkg::cfg_reg_e'(cfg_index_i))
        lbm_pkg::CFG_OMEGA0:     omega0_q     <= cfg_data_i;
        lbm_pkg::CFG_OMEGA1:     omega1_q     <= cfg_data_i;
        lbm_pkg::CFG_ROW_WIDTH:  row_width_q  <= cfg_data_i[lbm_pkg::ROW_W-1:0];
        lbm_pkg::CFG_NODE_COUNT: node_count_q <= cfg_data_i[lbm_pkg::COUNT_W-1:0];
        lbm_pkg::CFG_SLIP_NORTH: slip_north_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  lbm_front #(
    .VALUE_WIDTH    (VALUE_WIDTH),
    .NUM_COMPONENTS (NUM_COMPONENTS),
    .IN_TW          (IN_TW),
    .MAG_W          (MAG_W),
    .DATA_W         (DATA_W)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_data_i    (s_axis_tdata),
    .in_user_i    (s_axis_tuser),
    .omega0_i     (omega0_q),
    .omega1_i     (omega1_q),
    .row_width_i  (row_width_q),
    .node_count_i (node_count_q),
    .slip_north_i (slip_north_q),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_ctrl_o  (push_ctrl),
    .push_data_o  (push_data),
    .stat_o       (front_stat)
  );

  lbm_queue #(
    .DATA_W (DATA_W)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_ctrl_i  (push_ctrl),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_ctrl_o   (pop_ctrl),
    .pop_data_o   (pop_data),
    .stat_o       (queue_stat)
  );

  lbm_back #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .FRAC_BITS   (FRAC_BITS),
    .MAG_W       (MAG_W),
    .DATA_W      (DATA_W),
    .OUT_TW      (OUT_TW)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_ctrl_i  (pop_ctrl),
    .pop_data_i  (pop_data),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_user_o  (m_axis_tuser)
  );

`ifndef NO_ASSERTIONS
  // An accepted item always lands in the front register.
  a_accept_captured: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> front_stat.valid)
    else $error("accepted item not held in front register");

  // The input only stalls when the front is occupied and the queue is full.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> front_stat.valid && queue_stat.full)
    else $error("input stalled without a full queue");

  a_queue_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    queue_stat.full |-> !queue_stat.empty)
    else $error("queue reports full and empty at once");

  // Clamping only happens on relaxed items, which are always written.
  a_sat_written: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tuser[0])
    else $error("saturated result without write enable");
`endif

endmodule
